### sv/life_automaton_torus_step_core_defines.svh
// ----------------------------------------------------------------------------
// life_automaton_torus_step_core_defines
// Assertion macros used by the checker file of the board step core.
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_TORUS_STEP_CORE_DEFINES_SVH
`define LIFE_AUTOMATON_TORUS_STEP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define LATS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define LATS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/lats_pkg.sv
// ----------------------------------------------------------------------------
// lats_pkg
// Transaction types, request codes and controller commands of the board
// step core.
// ----------------------------------------------------------------------------
`default_nettype none

package lats_pkg;

    // Request kinds, echoed back on completion
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // B3/S23 neighbour counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [4:0]  row_index;
        logic [31:0] row_bits;
    } req_t;

    typedef struct packed {
        logic [31:0] row_data;
        logic [1:0]  done_kind;
    } rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;    // latch the accepted request
        logic wr_row;     // write the requested row
        logic rd_row;     // read the requested row
        logic rd_ptr;     // read the row at the sweep pointer
        logic rd_ahead;   // read the row two past the sweep pointer
        logic take_up;    // load the upper window row from read data
        logic take_mid;   // load the middle window row and the row-zero copy
        logic sweep;      // compute and write back the row at the pointer
        logic last;       // lower neighbour comes from the row-zero copy
        logic ret_read;   // return the read row
        logic ret_plain;  // return zero data
    } cmd_t;

endpackage

`default_nettype wire

### sv/lats_ram.sv
// ----------------------------------------------------------------------------
// lats_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lats_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/lats_ctrl.sv
// ----------------------------------------------------------------------------
// lats_ctrl
// Request sequencer: row write, row read and the generation sweep over
// all rows with the sweep pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module lats_ctrl #(
    parameter int BOARD_SIZE = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [1:0]                    req_type,
    output      logic                          busy,
    output      lats_pkg::cmd_t                cmd,
    output      logic [$clog2(BOARD_SIZE)-1:0] ptr
);

    localparam int IDX_W = $clog2(BOARD_SIZE);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRITE  = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_RWAIT  = 3'd3;
    localparam logic [2:0] S_FILL_A = 3'd4;
    localparam logic [2:0] S_FILL_B = 3'd5;
    localparam logic [2:0] S_FILL_C = 3'd6;
    localparam logic [2:0] S_SWEEP  = 3'd7;

    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(BOARD_SIZE - 1);
    localparam logic [IDX_W-1:0] AHEAD_LIM = IDX_W'(BOARD_SIZE - 2);

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] ptr_next;
    logic             accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign ptr    = ptr_reg;

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    unique case (req_type)
                        lats_pkg::KIND_WRITE: state_next = S_WRITE;
                        lats_pkg::KIND_READ:  state_next = S_READ;
                        lats_pkg::KIND_STEP:
                        begin
                            state_next = S_FILL_A;
                            ptr_next   = LAST_ROW;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.wr_row    = 1'b1;
                cmd.ret_plain = 1'b1;
                state_next    = S_IDLE;
            end
            S_READ:
            begin
                cmd.rd_row = 1'b1;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                cmd.ret_read = 1'b1;
                state_next   = S_IDLE;
            end
            S_FILL_A:
            begin
                // fetch the last row, the upper wrap neighbour of row zero
                cmd.rd_ptr = 1'b1;
                ptr_next   = '0;
                state_next = S_FILL_B;
            end
            S_FILL_B:
            begin
                cmd.take_up = 1'b1;
                cmd.rd_ptr  = 1'b1;
                ptr_next    = IDX_W'(1);
                state_next  = S_FILL_C;
            end
            S_FILL_C:
            begin
                cmd.take_mid = 1'b1;
                cmd.rd_ptr   = 1'b1;
                ptr_next     = '0;
                state_next   = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.sweep    = 1'b1;
                cmd.rd_ahead = (ptr_reg < AHEAD_LIM);
                cmd.last     = (ptr_reg == LAST_ROW);
                ptr_next     = ptr_reg + IDX_W'(1);
                if (ptr_reg == LAST_ROW)
                begin
                    cmd.ret_plain = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
    end

endmodule

`default_nettype wire

### sv/lats_dpath.sv
// ----------------------------------------------------------------------------
// lats_dpath
// Board memory, three-row window of old rows, B3/S23 next-row logic and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lats_dpath #(
    parameter int BOARD_SIZE = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lats_pkg::req_t                req,
    input  wire lats_pkg::cmd_t                cmd,
    input  wire logic [$clog2(BOARD_SIZE)-1:0] ptr,
    output      logic                          done,
    output      lats_pkg::rsp_t                rsp
);

    localparam int IDX_W = $clog2(BOARD_SIZE);

    lats_pkg::req_t        req_reg;
    logic [BOARD_SIZE-1:0] up_reg;
    logic [BOARD_SIZE-1:0] mid_reg;
    logic [BOARD_SIZE-1:0] first_reg;
    logic                  done_reg;
    lats_pkg::rsp_t        rsp_reg;

    logic [BOARD_SIZE-1:0] rd_data;
    logic [BOARD_SIZE-1:0] down;
    logic [BOARD_SIZE-1:0] new_row;
    logic [IDX_W-1:0]      req_addr;
    logic                  in_range;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [BOARD_SIZE-1:0] ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;

    assign req_addr = IDX_W'(req_reg.row_index);
    assign in_range = (int'(req_reg.row_index) < BOARD_SIZE);
    assign down     = cmd.last ? first_reg : rd_data;

    // one write port: sweep write-back or a row write inside the board
    always_comb
    begin
        ram_we    = cmd.sweep || (cmd.wr_row && in_range);
        ram_waddr = cmd.sweep ? ptr : req_addr;
        ram_wdata = cmd.sweep ? new_row : BOARD_SIZE'(req_reg.row_bits);
    end

    always_comb
    begin
        ram_re = cmd.rd_row || cmd.rd_ptr || cmd.rd_ahead;
        priority if (cmd.rd_row)
        begin
            ram_raddr = req_addr;
        end
        else if (cmd.rd_ahead)
        begin
            ram_raddr = ptr + IDX_W'(2);
        end
        else
        begin
            ram_raddr = ptr;
        end
    end

    lats_ram #(
        .WIDTH (BOARD_SIZE),
        .DEPTH (BOARD_SIZE)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // B3/S23 over the wrapped neighbourhood of every column
    always_comb
    begin : next_gen
        logic [BOARD_SIZE-1:0] up_w;
        logic [BOARD_SIZE-1:0] up_e;
        logic [BOARD_SIZE-1:0] mid_w;
        logic [BOARD_SIZE-1:0] mid_e;
        logic [BOARD_SIZE-1:0] dn_w;
        logic [BOARD_SIZE-1:0] dn_e;
        logic [3:0]            n;
        up_w  = {up_reg[BOARD_SIZE-2:0], up_reg[BOARD_SIZE-1]};
        up_e  = {up_reg[0], up_reg[BOARD_SIZE-1:1]};
        mid_w = {mid_reg[BOARD_SIZE-2:0], mid_reg[BOARD_SIZE-1]};
        mid_e = {mid_reg[0], mid_reg[BOARD_SIZE-1:1]};
        dn_w  = {down[BOARD_SIZE-2:0], down[BOARD_SIZE-1]};
        dn_e  = {down[0], down[BOARD_SIZE-1:1]};
        n     = '0;
        new_row = '0;
        for (int j = 0; j < BOARD_SIZE; j++)
        begin
            n = 4'(up_w[j]) + 4'(up_reg[j]) + 4'(up_e[j])
              + 4'(mid_w[j]) + 4'(mid_e[j])
              + 4'(dn_w[j]) + 4'(down[j]) + 4'(dn_e[j]);
            new_row[j] = (n == lats_pkg::BIRTH_COUNT)
                      || (mid_reg[j] && (n == lats_pkg::SURVIVE_COUNT));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.ret_read)
        begin
            rsp_reg.row_data  <= in_range ? 32'(rd_data) : '0;
            rsp_reg.done_kind <= req_reg.req_type;
        end
        else if (cmd.ret_plain)
        begin
            rsp_reg.row_data  <= '0;
            rsp_reg.done_kind <= req_reg.req_type;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg    <= '0;
            mid_reg   <= '0;
            first_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.ret_read || cmd.ret_plain;
            if (cmd.take_up)
            begin
                up_reg <= rd_data;
            end
            if (cmd.take_mid)
            begin
                mid_reg   <= rd_data;
                first_reg <= rd_data;
            end
            // advance the window by one row
            if (cmd.sweep)
            begin
                up_reg  <= mid_reg;
                mid_reg <= down;
            end
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

### sv/life_automaton_torus_step_core.sv
// ----------------------------------------------------------------------------
// life_automaton_torus_step_core
// A row write, a row read or a step runs from accept to the done strobe; busy
// is low again in the strobe cycle, and a new request is taken only when idle.
// A step sweeps the board one row a cycle through the single write port of
// the board RAM, after the window fill states FILL_A, FILL_B and FILL_C.
// Reset clears the controller, window and strobe; board rows are undefined
// until written. Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module life_automaton_torus_step_core #(
    parameter int BOARD_SIZE = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output      logic           busy,
    input  wire lats_pkg::req_t req,
    output      logic           done,
    output      lats_pkg::rsp_t rsp
);

    localparam int IDX_W = $clog2(BOARD_SIZE);

    lats_pkg::cmd_t   cmd;
    logic [IDX_W-1:0] ptr;

    lats_ctrl #(
        .BOARD_SIZE (BOARD_SIZE)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .busy     (busy),
        .cmd      (cmd),
        .ptr      (ptr)
    );

    lats_dpath #(
        .BOARD_SIZE (BOARD_SIZE)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .ptr   (ptr),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

### sv/lats_checker.sv
// ----------------------------------------------------------------------------
// lats_checker
// Port-level checks of the board step core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_automaton_torus_step_core_defines.svh"

module lats_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire lats_pkg::req_t req,
    input wire logic           done,
    input wire lats_pkg::rsp_t rsp
);

    `LATS_ASSERT_NXT(a_done_single, done, !done, "done strobe held for two cycles")
    `LATS_ASSERT_NXT(a_accept_busy, start && !busy && (req.req_type != lats_pkg::KIND_NONE), busy, "no busy after an accepted transaction")
    `LATS_ASSERT_IMP(a_write_done, start && !busy && (req.req_type == lats_pkg::KIND_WRITE), ##2 (done && (rsp.done_kind == lats_pkg::KIND_WRITE)), "row write not answered two cycles on")
    `LATS_ASSERT_IMP(a_kind_valid, done, rsp.done_kind != lats_pkg::KIND_NONE, "result with unused kind")
    `LATS_ASSERT_IMP(a_zero_data, done && (rsp.done_kind != lats_pkg::KIND_READ), rsp.row_data == 32'd0, "non-read result carries row data")

endmodule

bind life_automaton_torus_step_core lats_checker u_lats_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the torus board step core. Rows are written, read
// and stepped one transaction at a time. A board model in the bench predicts
// every strobed result but those given in the table, and each result is compared
// with the oldest pending one. After every row is written, a short table of
// directed transactions runs, then random transactions under several sender gap rates.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int BOARD_SIZE   = 32;
    localparam int RANDOM_ITEMS = 798;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PROBE_COUNT  = 22;

    typedef struct {
        logic [1:0]  kind;
        logic [4:0]  row;
        logic [31:0] bits;
        bit          typed;     // expected row_data given below, not predicted
        logic [31:0] data;
    } probe_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    lats_pkg::req_t req;
    lats_pkg::rsp_t rsp;

    logic [31:0]    board_rows [BOARD_SIZE];
    lats_pkg::rsp_t awaited_rsp [$];
    int unsigned    mismatch_count;
    int unsigned    cycle_count;

    // Directed transactions. The horizontal three-cell line at row 0 spans
    // columns 31, 0 and 1, so it oscillates across both wrap seams.
    probe_t probes [PROBE_COUNT] = '{
        '{lats_pkg::KIND_WRITE, 5'd0,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{lats_pkg::KIND_READ,  5'd0,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{lats_pkg::KIND_WRITE, 5'd31, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{lats_pkg::KIND_READ,  5'd31, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{lats_pkg::KIND_WRITE, 5'd31, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{lats_pkg::KIND_NONE,  5'd31, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{lats_pkg::KIND_READ,  5'd31, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{lats_pkg::KIND_WRITE, 5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},
        '{lats_pkg::KIND_WRITE, 5'd31, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{lats_pkg::KIND_WRITE, 5'd0,  32'h8000_0003, 1'b1, 32'h0000_0000},
        '{lats_pkg::KIND_STEP,  5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},
        '{lats_pkg::KIND_READ,  5'd31, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{lats_pkg::KIND_READ,  5'd0,  32'h0000_0000, 1'b0, 32'h0000_0000},
        '{lats_pkg::KIND_READ,  5'd1,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
        '{lats_pkg::KIND_STEP,  5'd31, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{lats_pkg::KIND_READ,  5'd0,  32'h0000_0000, 1'b0, 32'h0000_0000},
        '{lats_pkg::KIND_WRITE, 5'd16, 32'hAAAA_AAAA, 1'b1, 32'h0000_0000},
        '{lats_pkg::KIND_READ,  5'd16, 32'h0000_0000, 1'b1, 32'hAAAA_AAAA},
        '{lats_pkg::KIND_WRITE, 5'd17, 32'h5555_5555, 1'b1, 32'h0000_0000},
        '{lats_pkg::KIND_STEP,  5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},
        '{lats_pkg::KIND_READ,  5'd16, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{lats_pkg::KIND_READ,  5'd17, 32'h0000_0000, 1'b0, 32'h0000_0000}
    };

    life_automaton_torus_step_core #(
        .BOARD_SIZE (BOARD_SIZE)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, awaited_rsp.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Check each strobed result against the oldest pending one
    always @(posedge clk)
    begin
        lats_pkg::rsp_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (awaited_rsp.size() == 0)
                report_mismatch($sformatf("result with nothing pending, kind %0d data %h",
                                          rsp.done_kind, rsp.row_data));
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.done_kind !== want.done_kind)
                    report_mismatch($sformatf("done_kind %0d, want %0d",
                                              rsp.done_kind, want.done_kind));
                if (rsp.row_data !== want.row_data)
                    report_mismatch($sformatf("row_data %h, want %h (kind %0d)",
                                              rsp.row_data, want.row_data, want.done_kind));
            end
        end
    end

    // Offer one transaction, hold it until accepted, then update the board
    // model and queue the result it must produce, if any.
    task automatic apply_request(input lats_pkg::req_t r, input bit typed,
                                 input logic [31:0] typed_data);
        lats_pkg::rsp_t want;
        logic [31:0]    prev [BOARD_SIZE];
        logic [31:0]    up;
        logic [31:0]    mid;
        logic [31:0]    dn;
        int             cnt;
        int             w;
        int             e;
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy !== 1'b0);
        if (r.req_type != lats_pkg::KIND_NONE)
        begin
            want.row_data  = '0;
            want.done_kind = r.req_type;
            case (r.req_type)
                lats_pkg::KIND_WRITE: board_rows[r.row_index] = r.row_bits;
                lats_pkg::KIND_READ:  want.row_data = board_rows[r.row_index];
                lats_pkg::KIND_STEP:
                begin
                    prev = board_rows;
                    for (int i = 0; i < BOARD_SIZE; i++)
                    begin
                        up  = prev[(i + BOARD_SIZE - 1) % BOARD_SIZE];
                        mid = prev[i];
                        dn  = prev[(i + 1) % BOARD_SIZE];
                        for (int j = 0; j < BOARD_SIZE; j++)
                        begin
                            w   = (j + BOARD_SIZE - 1) % BOARD_SIZE;
                            e   = (j + 1) % BOARD_SIZE;
                            cnt = up[w] + up[j] + up[e] + mid[w] + mid[e]
                                + dn[w] + dn[j] + dn[e];
                            board_rows[i][j] = (cnt == 3) || (mid[j] && cnt == 2);
                        end
                    end
                end
                default: ;
            endcase
            if (typed)
                want.row_data = typed_data;
            awaited_rsp.push_back(want);
        end
    endtask

    initial
    begin
        lats_pkg::req_t r;
        int             gap_pct [3];
        int             sel;
        gap_pct        = '{0, 76, 34};
        rst_n          <= 1'b0;
        start          <= 1'b0;
        req            <= '0;
        mismatch_count = 0;
        cycle_count    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every row is written before any read or step
        for (int i = 0; i < BOARD_SIZE; i++)
        begin
            r = '{req_type: lats_pkg::KIND_WRITE, row_index: 5'(i), row_bits: 32'h0};
            apply_request(r, 1'b0, 32'h0);
        end

        foreach (probes[k])
        begin
            r = '{req_type: probes[k].kind, row_index: probes[k].row,
                  row_bits: probes[k].bits};
            apply_request(r, probes[k].typed, probes[k].data);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            // Hold off until the block has answered everything
            start <= 1'b0;
            do @(posedge clk); while (awaited_rsp.size() != 0);

            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                if ($urandom_range(99) < gap_pct[ph])
                begin
                    start <= 1'b0;
                    req   <= lats_pkg::req_t'({$urandom, $urandom});
                    do @(posedge clk); while ($urandom_range(99) < gap_pct[ph]);
                end
                sel         = $urandom_range(99);
                r.row_index = 5'($urandom_range(BOARD_SIZE - 1));
                r.row_bits  = $urandom;
                if (sel < 30)
                begin
                    r.req_type = lats_pkg::KIND_WRITE;
                    // Mostly sparse rows, so the board neither dies nor boils
                    case ($urandom_range(7))
                        0, 1:    r.row_bits = $urandom;
                        2:       r.row_bits = 32'h0;
                        3:       r.row_bits = 32'hFFFF_FFFF;
                        default: r.row_bits = $urandom & $urandom & $urandom;
                    endcase
                end
                else if (sel < 65)
                    r.req_type = lats_pkg::KIND_READ;
                else if (sel < 94)
                    r.req_type = lats_pkg::KIND_STEP;
                else
                    r.req_type = lats_pkg::KIND_NONE;
                apply_request(r, 1'b0, 32'h0);
            end
        end

        start <= 1'b0;
        do @(posedge clk); while (awaited_rsp.size() != 0);
        repeat (BOARD_SIZE + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### life_automaton_torus_step_core.f
+incdir+sv
sv/lats_pkg.sv
sv/lats_ram.sv
sv/lats_ctrl.sv
sv/lats_dpath.sv
sv/life_automaton_torus_step_core.sv
sv/lats_checker.sv
test/tb_top.sv
